### design/jet_pkg.sv
`timescale 1ns / 1ps
package jet_pkg;

  typedef enum logic [3:0] {
    EV_OBJS = 4'd0,
    EV_OBJE = 4'd1,
    EV_ARRS = 4'd2,
    EV_ARRE = 4'd3,
    EV_KEY  = 4'd4,
    EV_STR  = 4'd5,
    EV_NUM  = 4'd6,
    EV_BOOL = 4'd7,
    EV_NULL = 4'd8,
    EV_END  = 4'd9,
    EV_ERR  = 4'd10
  } ev_code_e;

  // literal kinds
  localparam logic [1:0] LK_TRUE  = 2'd0;
  localparam logic [1:0] LK_FALSE = 2'd1;
  localparam logic [1:0] LK_NULL  = 2'd2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  // one event as it leaves the block
  typedef struct packed {
    ev_code_e    code;
    logic [31:0] start;
    logic [31:0] len;
    logic        bv;
    logic [5:0]  lvl;
  } ev_t;

  // up to three events caused by one byte, in order
  typedef struct packed {
    logic [1:0]     cnt;
    ev_t [2:0]      ev;
  } bundle_t;

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      LK_TRUE:  r = 3'd4;
      LK_FALSE: r = 3'd5;
      default:  r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [39:0] s;
    logic [7:0]  r;
    case (k)
      LK_TRUE:  s = {8'h00, "eurt"};
      LK_FALSE: s = "eslaf";
      default:  s = {8'h00, "llun"};
    endcase
    r = 8'h00;
    case (i)
      3'd0: r = s[7:0];
      3'd1: r = s[15:8];
      3'd2: r = s[23:16];
      3'd3: r = s[31:24];
      3'd4: r = s[39:32];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### design/jet_if.sv
`timescale 1ns / 1ps
interface jet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_doc;
  modport source (output valid, output data_byte, output end_of_doc, input ready);
  modport sink   (input valid, input data_byte, input end_of_doc, output ready);
endinterface

interface jet_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic        lit_value;
  logic [5:0]  nest_level;
  logic        last_of_run;
  modport source (output valid, output event_code, output token_start,
                  output token_length, output lit_value, output nest_level,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_code, input token_start,
                  input token_length, input lit_value, input nest_level,
                  input last_of_run, output ready);
endinterface

### design/jet_front.sv
`timescale 1ns / 1ps
module jet_front import jet_pkg::*; #(
  parameter int MAX_NEST    = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       room_i,
  output logic       in_ready_o,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam int OW = OFFSET_BITS;

  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_STR   = 6'b000010,
    M_ESC   = 6'b000100,
    M_NUM   = 6'b001000,
    M_LIT   = 6'b010000,
    M_DRAIN = 6'b100000
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [MAX_NEST-1:0] stk_q, stk_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic                ek_q, ek_d;
  logic [2:0]          lp_q, lp_d;
  logic [1:0]          lk_q, lk_d;
  logic                sk_q, sk_d;
  logic [OW-1:0]       tb_q, tb_d;
  logic [OW-1:0]       off_q, off_d;

  logic                accept;
  ev_t [3:0]           evs;
  logic [1:0]          n;

  function automatic logic [31:0] sat32(input logic [OW-1:0] x);
    logic [OW+31:0] w;
    w = {32'b0, x};
    return (|w[OW+31:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [OW-1:0] inc_off(input logic [OW-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic [5:0] lvl6(input logic [DW-1:0] d);
    logic [DW+5:0] w;
    w = {6'b0, d};
    return w[5:0];
  endfunction

  function automatic ev_t mk(input ev_code_e c, input logic [31:0] s,
                             input logic [31:0] l, input logic b,
                             input logic [DW-1:0] d);
    ev_t e;
    e.code  = c;
    e.start = s;
    e.len   = l;
    e.bv    = b;
    e.lvl   = lvl6(d);
    return e;
  endfunction

  assign accept     = in_valid_i && room_i;
  assign in_ready_o = room_i;

  // byte classification and state update, events collected in order
  always_comb begin
    logic          tio;
    logic          do_idle;
    logic          is_obj;
    logic [MAX_NEST-1:0] stk_pop;
    logic [1:0]    k;
    logic [7:0]    c;
    logic          numc;
    logic [OW-1:0] sp;

    mode_d  = mode_q;
    stk_d   = stk_q;
    depth_d = depth_q;
    ek_d    = ek_q;
    lp_d    = lp_q;
    lk_d    = lk_q;
    sk_d    = sk_q;
    tb_d    = tb_q;
    evs     = '0;
    n       = 2'd0;
    c       = in_byte_i;
    tio     = (depth_q != '0) && stk_q[0];
    stk_pop = stk_q >> 1;
    is_obj  = (c == CH_LBRACE);
    k       = (lk_q == 2'd3) ? LK_NULL : lk_q;
    numc    = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_LOW_E ||
              c == CH_UP_E || c == CH_PLUS || c == CH_MINUS;
    sp      = (off_q >= tb_q) ? off_q - tb_q : '0;
    do_idle = 1'b0;

    case (mode_q)
      M_IDLE: do_idle = 1'b1;
      M_STR: begin
        if (c == CH_QUOTE) begin
          evs[n] = mk(sk_q ? EV_KEY : EV_STR, sat32(tb_q), sat32(sp), 1'b0, depth_d);
          n = n + 1'b1;
          if (sk_q) ek_d = 1'b0;
          else if (tio) ek_d = 1'b1;
          mode_d = M_IDLE;
        end else if (c == CH_BSLASH) begin
          mode_d = M_ESC;
        end
      end
      M_ESC: mode_d = M_STR;
      M_NUM: begin
        if (!numc) begin
          evs[n] = mk(EV_NUM, sat32(tb_q), sat32(sp), 1'b0, depth_d);
          n = n + 1'b1;
          if (tio) ek_d = 1'b1;
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_LIT: begin
        if (lp_q >= lit_len(k) || lit_char(k, lp_q) != c) begin
          evs[n] = mk(EV_ERR, sat32(off_q), 32'd0, 1'b0, depth_d);
          n = n + 1'b1;
          mode_d = M_DRAIN;
        end else begin
          lp_d = lp_q + 1'b1;
          if (lp_d == lit_len(k)) begin
            evs[n] = mk((k == LK_NULL) ? EV_NULL : EV_BOOL, sat32(tb_q),
                        {29'd0, lit_len(k)}, k == LK_TRUE, depth_d);
            n = n + 1'b1;
            if (tio) ek_d = 1'b1;
            mode_d = M_IDLE;
          end
        end
      end
      default: ;
    endcase

    // handling of a byte between tokens
    if (do_idle) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
          c == CH_COLON) begin
        // skipped
      end else if (c == CH_COMMA) begin
        if (tio) ek_d = 1'b1;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        if (depth_q >= DW'(MAX_NEST)) begin
          evs[n] = mk(EV_ERR, sat32(off_q), 32'd0, 1'b0, depth_d);
          n = n + 1'b1;
          mode_d = M_DRAIN;
        end else begin
          stk_d   = (stk_q << 1) | MAX_NEST'(is_obj);
          depth_d = depth_q + 1'b1;
          ek_d    = is_obj;
          evs[n] = mk(is_obj ? EV_OBJS : EV_ARRS, sat32(off_q), 32'd0, 1'b0, depth_d);
          n = n + 1'b1;
        end
      end else if (c == CH_RBRACE || c == CH_RBRACK) begin
        if (depth_q == '0) begin
          evs[n] = mk(EV_ERR, sat32(off_q), 32'd0, 1'b0, depth_d);
          n = n + 1'b1;
          mode_d = M_DRAIN;
        end else begin
          stk_d   = stk_pop;
          depth_d = depth_q - 1'b1;
          ek_d    = (depth_d != '0) && stk_pop[0];
          evs[n] = mk((c == CH_RBRACE) ? EV_OBJE : EV_ARRE, sat32(off_q), 32'd0,
                      1'b0, depth_d);
          n = n + 1'b1;
        end
      end else if (c == CH_QUOTE) begin
        sk_d   = ek_d && tio;
        tb_d   = inc_off(off_q);
        mode_d = M_STR;
      end else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
        tb_d   = off_q;
        mode_d = M_NUM;
      end else if (c == CH_LOW_T || c == CH_LOW_F || c == CH_LOW_N) begin
        lk_d   = (c == CH_LOW_T) ? LK_TRUE : (c == CH_LOW_F) ? LK_FALSE : LK_NULL;
        lp_d   = 3'd1;
        tb_d   = off_q;
        mode_d = M_LIT;
      end else begin
        evs[n] = mk(EV_ERR, sat32(off_q), 32'd0, 1'b0, depth_d);
        n = n + 1'b1;
        mode_d = M_DRAIN;
      end
    end

    off_d = inc_off(off_q);

    // last byte: flush pending token, clear state, close with END if the bundle has room
    if (in_last_i) begin
      sp = (off_d >= tb_d) ? off_d - tb_d : '0;
      if (mode_d == M_NUM) begin
        evs[n] = mk(EV_NUM, sat32(tb_d), sat32(sp), 1'b0, depth_d);
        n = n + 1'b1;
      end else if (mode_d == M_STR || mode_d == M_ESC || mode_d == M_LIT) begin
        evs[n] = mk(EV_ERR, sat32(off_q), 32'd0, 1'b0, depth_d);
        n = n + 1'b1;
      end
      if (n != 2'd3) begin
        evs[n] = mk(EV_END, sat32(off_d), 32'd0, 1'b0, '0);
        n = n + 1'b1;
      end
      mode_d  = M_IDLE;
      depth_d = '0;
      ek_d    = 1'b0;
      lp_d    = 3'd0;
      lk_d    = 2'd0;
      sk_d    = 1'b0;
      tb_d    = '0;
      off_d   = '0;
    end
  end

  assign push_o       = accept && (n != 2'd0);
  assign bundle_o.cnt = n;
  assign bundle_o.ev  = evs[2:0];

  // scope stack: shift line, top of stack at bit 0, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stk_q <= stk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      depth_q <= '0;
      ek_q    <= 1'b0;
      lp_q    <= 3'd0;
      lk_q    <= 2'd0;
      sk_q    <= 1'b0;
      tb_q    <= '0;
      off_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      ek_q    <= ek_d;
      lp_q    <= lp_d;
      lk_q    <= lk_d;
      sk_q    <= sk_d;
      tb_q    <= tb_d;
      off_q   <= off_d;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_NEST)) else $error("nesting depth above limit");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> depth_q == '0 && mode_q == M_IDLE && off_q == '0)
    else $error("state not cleared after last byte");
  a_last_has_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |-> push_o) else $error("last byte gave no events");
`endif

endmodule

### design/jet_fifo.sv
`timescale 1ns / 1ps
module jet_fifo import jet_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t wdata_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    avail_o,
  output bundle_t rdata_o
);

  bundle_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign room_o  = cnt_q != 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rp_q];

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
`endif

endmodule

### design/jet_back.sv
`timescale 1ns / 1ps
module jet_back import jet_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  bundle_t head_i,
  output logic    pop_o,
  jet_out_if.source out_ch
);

  logic [1:0] idx_q;
  logic       last_ev;
  ev_t        cur;

  assign cur     = head_i.ev[idx_q];
  assign last_ev = (idx_q == head_i.cnt - 2'd1);

  assign out_ch.valid        = avail_i;
  assign out_ch.event_code   = cur.code;
  assign out_ch.token_start  = cur.start;
  assign out_ch.token_length = cur.len;
  assign out_ch.lit_value    = cur.bv;
  assign out_ch.nest_level   = cur.lvl;
  assign out_ch.last_of_run  = last_ev;

  assign pop_o = avail_i && out_ch.ready && last_ev;

  // walk the events of the head bundle, one beat each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (avail_i && out_ch.ready) begin
      idx_q <= last_ev ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avail_i |-> idx_q < head_i.cnt) else $error("event index past bundle");
  a_idx_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !avail_i |-> idx_q == 2'd0) else $error("index held with empty queue");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> out_ch.last_of_run) else $error("pop before last event");
`endif

endmodule

### design/json_event_tokenizer_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                                   Beat
// in_ch    in   data_byte[7:0], end_of_doc                                one byte
// out_ch   out  event_code, token_start, token_length, lit_value,
//               nest_level, last_of_run                                   one event
//
// One byte is taken per cycle; a byte that raises several events gives one output
// beat for each of them, and a two-bundle queue between the classifier and the event
// serializer lets the input keep running while those are drained.
// The input stalls only when the queue is full. Reset is asynchronous, active
// low, and clears the scanner, depth and byte offset; the stack needs none.
module json_event_tokenizer_core import jet_pkg::*; #(
  parameter int MAX_NEST    = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jet_in_if.sink    in_ch,
  jet_out_if.source out_ch
);

  logic    room, avail, push, pop;
  bundle_t wbundle, rbundle;

  jet_front #(
    .MAX_NEST    (MAX_NEST),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_byte_i  (in_ch.data_byte),
    .in_last_i  (in_ch.end_of_doc),
    .room_i     (room),
    .in_ready_o (in_ch.ready),
    .push_o     (push),
    .bundle_o   (wbundle)
  );

  jet_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .pop_i   (pop),
    .room_o  (room),
    .avail_o (avail),
    .rdata_o (rbundle)
  );

  jet_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (rbundle),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

### bench/jet_checker.sv
`timescale 1ns / 1ps
module jet_checker import jet_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jet_in_if         in_ch,
  jet_out_if        out_ch,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int NEST_MAX = 32;

  typedef enum logic [2:0] {
    SC_IDLE, SC_STR, SC_ESC, SC_NUM, SC_LIT, SC_DRAIN
  } scan_e;

  typedef struct packed {
    ev_code_e    code;
    logic [31:0] start;
    logic [31:0] len;
    logic        bv;
    logic [5:0]  lvl;
    logic        last;
  } event_t;

  // tokenizer state mirror
  logic [NEST_MAX-1:0] scopes;
  int unsigned         depth;
  logic                want_key;
  scan_e               scan;
  int unsigned         lit_pos;
  logic [1:0]          lit_kind;
  logic                is_key;
  logic [31:0]         tok_begin;
  logic [31:0]         offset;

  event_t event_q[$];
  event_t step_evs[$];
  int     fails;

  assign fail_count_o = fails;

  task automatic report(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic void clear_state();
    scopes    = '0;
    depth     = 0;
    want_key  = 1'b0;
    scan      = SC_IDLE;
    lit_pos   = 0;
    lit_kind  = LK_TRUE;
    is_key    = 1'b0;
    tok_begin = '0;
    offset    = '0;
  endfunction

  function automatic void emit(input ev_code_e code, input logic [31:0] st,
                               input logic [31:0] ln, input logic bv);
    event_t e;
    if (step_evs.size() >= 3) return;
    e.code  = code;
    e.start = st;
    e.len   = ln;
    e.bv    = bv;
    e.lvl   = depth[5:0];
    e.last  = 1'b0;
    step_evs.push_back(e);
  endfunction

  function automatic logic top_obj();
    return depth > 0 && depth <= NEST_MAX && scopes[depth-1];
  endfunction

  function automatic void raise_err(input logic [31:0] off);
    emit(EV_ERR, off, '0, 1'b0);
    scan = SC_DRAIN;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic [31:0] body_len(input logic [31:0] off);
    return (off >= tok_begin) ? off - tok_begin : '0;
  endfunction

  function automatic void value_closed();
    if (top_obj()) want_key = 1'b1;
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_LOW_E ||
           c == CH_UP_E || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic [7:0] lit_byte(input logic [1:0] k, input int unsigned i);
    string s;
    s = (k == LK_TRUE) ? "true" : (k == LK_FALSE) ? "false" : "null";
    return (i < s.len()) ? s[i] : 8'h00;
  endfunction

  function automatic int unsigned lit_size(input logic [1:0] k);
    return (k == LK_FALSE) ? 5 : 4;
  endfunction

  // byte seen between tokens
  function automatic void between_tokens(input logic [7:0] c, input logic [31:0] off);
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_COLON)
      return;
    if (c == CH_COMMA) begin
      if (top_obj()) want_key = 1'b1;
    end else if (c == CH_LBRACE || c == CH_LBRACK) begin
      if (depth >= NEST_MAX) begin
        raise_err(off);
        return;
      end
      scopes[depth] = (c == CH_LBRACE);
      depth++;
      want_key = (c == CH_LBRACE);
      emit(c == CH_LBRACE ? EV_OBJS : EV_ARRS, off, '0, 1'b0);
    end else if (c == CH_RBRACE || c == CH_RBRACK) begin
      if (depth == 0) begin
        raise_err(off);
        return;
      end
      depth--;
      want_key = top_obj();
      emit(c == CH_RBRACE ? EV_OBJE : EV_ARRE, off, '0, 1'b0);
    end else if (c == CH_QUOTE) begin
      is_key    = want_key && top_obj();
      tok_begin = sat_inc(off);
      scan      = SC_STR;
    end else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
      tok_begin = off;
      scan      = SC_NUM;
    end else if (c == CH_LOW_T || c == CH_LOW_F || c == CH_LOW_N) begin
      lit_kind  = (c == CH_LOW_T) ? LK_TRUE : (c == CH_LOW_F) ? LK_FALSE : LK_NULL;
      lit_pos   = 1;
      tok_begin = off;
      scan      = SC_LIT;
    end else begin
      raise_err(off);
    end
  endfunction

  // one accepted byte -> expected events
  function automatic void predict_byte(input logic [7:0] c, input logic last);
    logic [31:0] off, doc_len;
    off = offset;
    step_evs.delete();
    case (scan)
      SC_IDLE: between_tokens(c, off);
      SC_STR: begin
        if (c == CH_QUOTE) begin
          emit(is_key ? EV_KEY : EV_STR, tok_begin, body_len(off), 1'b0);
          if (is_key) want_key = 1'b0;
          else value_closed();
          scan = SC_IDLE;
        end else if (c == CH_BSLASH) begin
          scan = SC_ESC;
        end
      end
      SC_ESC: scan = SC_STR;
      SC_NUM: begin
        if (!is_num_char(c)) begin
          emit(EV_NUM, tok_begin, body_len(off), 1'b0);
          value_closed();
          scan = SC_IDLE;
          between_tokens(c, off);
        end
      end
      SC_LIT: begin
        if (lit_pos >= lit_size(lit_kind) || lit_byte(lit_kind, lit_pos) != c) begin
          raise_err(off);
        end else begin
          lit_pos++;
          if (lit_pos == lit_size(lit_kind)) begin
            emit(lit_kind == LK_NULL ? EV_NULL : EV_BOOL, tok_begin,
                 lit_size(lit_kind), lit_kind == LK_TRUE);
            value_closed();
            scan = SC_IDLE;
          end
        end
      end
      default: ;
    endcase
    offset = sat_inc(off);
    if (last) begin
      doc_len = offset;
      if (scan == SC_NUM) emit(EV_NUM, tok_begin, body_len(doc_len), 1'b0);
      else if (scan == SC_STR || scan == SC_ESC || scan == SC_LIT)
        emit(EV_ERR, off, '0, 1'b0);
      clear_state();
      emit(EV_END, doc_len, '0, 1'b0);
    end
    if (step_evs.size() > 0) step_evs[step_evs.size()-1].last = 1'b1;
    foreach (step_evs[i]) event_q.push_back(step_evs[i]);
  endfunction

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    event_t e;
    if (!rst_ni) begin
      clear_state();
      event_q.delete();
      fails     = 0;
      pending_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (event_q.size() == 0) begin
          report($sformatf("unexpected event code %0d", out_ch.event_code));
        end else begin
          e = event_q.pop_front();
          if (out_ch.event_code !== e.code)
            report($sformatf("event_code %0d, want %0d", out_ch.event_code, e.code));
          if (out_ch.token_start !== e.start)
            report($sformatf("token_start %0d, want %0d", out_ch.token_start, e.start));
          if (out_ch.token_length !== e.len)
            report($sformatf("token_length %0d, want %0d", out_ch.token_length, e.len));
          if (out_ch.lit_value !== e.bv)
            report($sformatf("lit_value %0b, want %0b", out_ch.lit_value, e.bv));
          if (out_ch.nest_level !== e.lvl)
            report($sformatf("nest_level %0d, want %0d", out_ch.nest_level, e.lvl));
          if (out_ch.last_of_run !== e.last)
            report($sformatf("last_of_run %0b, want %0b", out_ch.last_of_run, e.last));
        end
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.end_of_doc);
      pending_o = event_q.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import jet_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   bytes_sent;

  jet_in_if  in_ch ();
  jet_out_if out_ch ();

  json_event_tokenizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jet_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls, with calm stretches
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready = 1'b0;
          repeat (n) @(negedge clk_i);
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // send one byte, holding valid until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input logic gaps);
    int n;
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.end_of_doc <= last;
    do @(posedge clk_i); while (!(in_ch.ready === 1'b1));
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic gaps);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, gaps);
  endtask

  function automatic string rand_scalar();
    string s;
    string num_chars;
    int n;
    int k;
    num_chars = "0123456789.eE+-";
    case ($urandom_range(0, 5))
      0: s = "true";
      1: s = "false";
      2: s = "null";
      3: begin
        s = "-";
        n = $urandom_range(1, 4);
        repeat (n) begin
          k = $urandom_range(0, 14);
          s = {s, num_chars.substr(k, k)};
        end
      end
      4: begin
        s = "\"";
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) s = {s, "\\\""};
          else s = {s, $sformatf("%c", 8'($urandom_range(8'h23, 8'h5B)))};
        end
        s = {s, "\""};
      end
      default: begin
        k = $urandom_range(0, 9);
        s = num_chars.substr(k, k);
      end
    endcase
    return s;
  endfunction

  function automatic string rand_value(input int lvl);
    string s;
    int n;
    if (lvl > 3 || $urandom_range(0, 2) == 0) return rand_scalar();
    n = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      s = "{";
      for (int i = 0; i < n; i++) begin
        if (i) s = {s, ","};
        s = {s, "\"k\": ", rand_value(lvl + 1)};
      end
      s = {s, "}"};
    end else begin
      s = "[";
      for (int i = 0; i < n; i++) begin
        if (i) s = {s, ", "};
        s = {s, rand_value(lvl + 1)};
      end
      s = {s, "]"};
    end
    return s;
  endfunction

  initial begin
    string doc;
    int    n;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.end_of_doc = 1'b0;
    rst_ni           = 1'b0;
    bytes_sent       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: brackets, keys, literals, numbers, escapes, errors
    send_text("{\"a\":[true,false,null,-1.5e+3]}", 1'b0);
    send_text("\"x\\\"y", 1'b0);
    send_text("tx", 1'b0);
    send_text("]", 1'b0);
    send_text("12", 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);

    // hold off until all events drained
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);

    // nest past the stack limit
    for (int i = 0; i < 33; i++) send_byte(CH_LBRACK, 1'b0, 1'b1);
    send_byte(CH_RBRACK, 1'b1, 1'b1);

    // random documents, mostly well formed
    while (bytes_sent < 205) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b1);
      end else begin
        doc = rand_value(0);
        if ($urandom_range(0, 5) == 0) doc = doc.substr(0, doc.len() / 2);
        send_text(doc, 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### json_event_tokenizer_core.f
design/jet_pkg.sv
design/jet_if.sv
design/jet_front.sv
design/jet_fifo.sv
design/jet_back.sv
design/json_event_tokenizer_core.sv
bench/jet_checker.sv
bench/testbench.sv
